// ===== rtl/kear_pkg.sv =====
// Shared types and constants for the key edge and autorepeat block.
package kear_pkg;

  // Configuration register indexes.
  localparam logic CFG_SHIFT_DELAY   = 1'b0;
  localparam logic CFG_REPEAT_PERIOD = 1'b1;

  localparam logic [7:0] SHIFT_DELAY_RST   = 8'd10;
  localparam logic [7:0] REPEAT_PERIOD_RST = 8'd2;

  // Horizontal move codes, two bit signed.
  typedef logic signed [1:0] move_t;
  localparam move_t MOVE_NONE  = 2'sb00;
  localparam move_t MOVE_RIGHT = 2'sb01;
  localparam move_t MOVE_LEFT  = 2'sb11;

  typedef struct packed {
    logic up;
    logic x;
    logic z;
    logic space;
    logic r;
    logic esc;
    logic left;
    logic a;
    logic right;
    logic d;
    logic down;
    logic s;
  } raw_keys_t;

  typedef struct packed {
    logic cw;
    logic ccw;
    logic space;
    logic restart;
    logic escape;
  } action_t;

  typedef struct packed {
    logic    left;
    logic    right;
    logic    down;
    action_t pulse;
  } key_state_t;

endpackage

// ===== rtl/kear_keymap.sv =====
// Alias merging and rising-edge detection of the action keys.
module kear_keymap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  kear_pkg::raw_keys_t   raw_i,
  output kear_pkg::key_state_t  keys_o
);

  kear_pkg::action_t now;
  kear_pkg::action_t prev_q;
  kear_pkg::action_t prev_d;

  always_comb begin
    now.cw      = raw_i.up | raw_i.x;
    now.ccw     = raw_i.z;
    now.space   = raw_i.space;
    now.restart = raw_i.r;
    now.escape  = raw_i.esc;

    keys_o.left  = raw_i.left | raw_i.a;
    keys_o.right = raw_i.right | raw_i.d;
    keys_o.down  = raw_i.down | raw_i.s;
    keys_o.pulse = now & ~prev_q;

    prev_d = step_i ? now : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== rtl/kear_shift.sv =====
// Delayed auto shift: immediate move on a new direction, then delay and repeat.
module kear_shift (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                left_i,
  input  logic                right_i,
  input  logic [7:0]          shift_delay_i,
  input  logic [7:0]          repeat_period_i,
  output kear_pkg::move_t     move_o
);

  kear_pkg::move_t dir;
  kear_pkg::move_t dir_q;
  kear_pkg::move_t dir_d;
  logic [7:0]      delay_q;
  logic [7:0]      delay_d;
  logic [7:0]      period_q;
  logic [7:0]      period_d;
  logic [7:0]      period_inc;

  always_comb begin
    if (left_i && !right_i) begin
      dir = kear_pkg::MOVE_LEFT;
    end else if (right_i && !left_i) begin
      dir = kear_pkg::MOVE_RIGHT;
    end else begin
      dir = kear_pkg::MOVE_NONE;
    end

    // The period counter stays below the period before the add, so no wrap.
    period_inc = period_q + 8'd1;

    dir_d    = dir_q;
    delay_d  = delay_q;
    period_d = period_q;
    move_o   = kear_pkg::MOVE_NONE;

    if (dir == kear_pkg::MOVE_NONE) begin
      dir_d    = kear_pkg::MOVE_NONE;
      delay_d  = '0;
      period_d = '0;
    end else if (dir_q != dir) begin
      dir_d    = dir;
      delay_d  = '0;
      period_d = '0;
      move_o   = dir;
    end else if (delay_q < shift_delay_i) begin
      delay_d = delay_q + 8'd1;
    end else if (period_inc < repeat_period_i) begin
      period_d = period_inc;
    end else begin
      period_d = '0;
      move_o   = dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= kear_pkg::MOVE_NONE;
      delay_q  <= '0;
      period_q <= '0;
    end else if (step_i) begin
      dir_q    <= dir_d;
      delay_q  <= delay_d;
      period_q <= period_d;
    end
  end

endmodule

// ===== rtl/key_edge_and_autorepeat.sv =====
// Top level of the key edge detector and horizontal autorepeat.
// One input beat is one tick of twelve raw key levels; one output beat follows
// for each, carrying merged levels, action-key press pulses and a move of
// -1, 0 or +1. The block takes one beat per cycle while the output is not
// stalled: a beat is registered at the input, processed by the alias, edge and
// delayed-auto-shift logic, and then moves into the output register once that
// is free, while the next beat is already taken. Stalls on the output side back
// up through the two registers.
// Write shift_delay and repeat_period only while no beat is in flight.
module key_edge_and_autorepeat (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       key_up_i,
  input  logic       key_x_i,
  input  logic       key_z_i,
  input  logic       key_space_i,
  input  logic       key_r_i,
  input  logic       key_esc_i,
  input  logic       key_left_i,
  input  logic       key_a_i,
  input  logic       key_right_i,
  input  logic       key_d_i,
  input  logic       key_down_i,
  input  logic       key_s_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       left_level_o,
  output logic       right_level_o,
  output logic       down_level_o,
  output logic       rotate_cw_pulse_o,
  output logic       rotate_ccw_pulse_o,
  output logic       space_pulse_o,
  output logic       restart_pulse_o,
  output logic       escape_pulse_o,
  output logic [1:0] horizontal_move_o
);

  logic [7:0]            shift_delay_q;
  logic [7:0]            repeat_period_q;
  logic                  in_valid_q;
  kear_pkg::raw_keys_t   raw_q;
  logic                  out_valid_q;
  kear_pkg::key_state_t  keys;
  kear_pkg::key_state_t  keys_q;
  kear_pkg::move_t       move;
  kear_pkg::move_t       move_q;
  logic                  advance;

  // The registered input moves on whenever the output register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_delay_q   <= kear_pkg::SHIFT_DELAY_RST;
      repeat_period_q <= kear_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kear_pkg::CFG_SHIFT_DELAY:   shift_delay_q   <= cfg_data_i;
        kear_pkg::CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q <= '{up: key_up_i, x: key_x_i, z: key_z_i, space: key_space_i,
                 r: key_r_i, esc: key_esc_i, left: key_left_i, a: key_a_i,
                 right: key_right_i, d: key_d_i, down: key_down_i,
                 s: key_s_i};
    end
    if (advance) begin
      keys_q <= keys;
      move_q <= move;
    end
  end

  kear_keymap u_keymap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .raw_i  (raw_q),
    .keys_o (keys)
  );

  kear_shift u_shift (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .left_i          (keys.left),
    .right_i         (keys.right),
    .shift_delay_i   (shift_delay_q),
    .repeat_period_i (repeat_period_q),
    .move_o          (move)
  );

  assign out_valid_o        = out_valid_q;
  assign left_level_o       = keys_q.left;
  assign right_level_o      = keys_q.right;
  assign down_level_o       = keys_q.down;
  assign rotate_cw_pulse_o  = keys_q.pulse.cw;
  assign rotate_ccw_pulse_o = keys_q.pulse.ccw;
  assign space_pulse_o      = keys_q.pulse.space;
  assign restart_pulse_o    = keys_q.pulse.restart;
  assign escape_pulse_o     = keys_q.pulse.escape;
  assign horizontal_move_o  = move_q;

`ifndef SYNTHESIS
  // A move never has the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (move_q != 2'sb10))
    else $error("invalid horizontal move code");

  // Both or neither direction held gives no move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (keys_q.left == keys_q.right)) |-> (move_q == kear_pkg::MOVE_NONE))
    else $error("move without a single held direction");

  // A left move comes only with left held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (move_q == kear_pkg::MOVE_LEFT)) |-> keys_q.left)
    else $error("left move without left held");

  // A beat waiting at the output is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== bench/key_edge_and_autorepeat_tb.sv =====
// Self-checking testbench for the key edge detector and horizontal autorepeat.
`timescale 1ns / 100ps

module key_edge_and_autorepeat_tb;

  typedef struct packed {
    kear_pkg::key_state_t keys;
    kear_pkg::move_t      move;
  } tick_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       key_up_i, key_x_i, key_z_i, key_space_i, key_r_i, key_esc_i;
  logic       key_left_i, key_a_i, key_right_i, key_d_i, key_down_i, key_s_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       left_level_o, right_level_o, down_level_o;
  logic       rotate_cw_pulse_o, rotate_ccw_pulse_o, space_pulse_o;
  logic       restart_pulse_o, escape_pulse_o;
  logic [1:0] horizontal_move_o;

  key_edge_and_autorepeat dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .key_up_i           (key_up_i),
    .key_x_i            (key_x_i),
    .key_z_i            (key_z_i),
    .key_space_i        (key_space_i),
    .key_r_i            (key_r_i),
    .key_esc_i          (key_esc_i),
    .key_left_i         (key_left_i),
    .key_a_i            (key_a_i),
    .key_right_i        (key_right_i),
    .key_d_i            (key_d_i),
    .key_down_i         (key_down_i),
    .key_s_i            (key_s_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .left_level_o       (left_level_o),
    .right_level_o      (right_level_o),
    .down_level_o       (down_level_o),
    .rotate_cw_pulse_o  (rotate_cw_pulse_o),
    .rotate_ccw_pulse_o (rotate_ccw_pulse_o),
    .space_pulse_o      (space_pulse_o),
    .restart_pulse_o    (restart_pulse_o),
    .escape_pulse_o     (escape_pulse_o),
    .horizontal_move_o  (horizontal_move_o)
  );

  // Predictor state: the block's registers and counters as seen from outside.
  logic [7:0]        shift_delay_q   = kear_pkg::SHIFT_DELAY_RST;
  logic [7:0]        repeat_period_q = kear_pkg::REPEAT_PERIOD_RST;
  kear_pkg::action_t prev_actions    = '0;
  kear_pkg::move_t   held_dir        = kear_pkg::MOVE_NONE;
  logic [7:0]        delay_cnt       = '0;
  logic [7:0]        period_cnt      = '0;

  tick_result_t expected_ticks[$];
  int           mismatches        = 0;
  bit           feed_idle         = 1'b0;
  bit           sink_idle         = 1'b0;
  int           sink_hold_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic tick_result_t predict_tick(input kear_pkg::raw_keys_t k);
    tick_result_t      res;
    kear_pkg::action_t now_act;
    logic              lv, rv;
    kear_pkg::move_t   want;
    lv = k.left | k.a;
    rv = k.right | k.d;
    now_act.cw      = k.up | k.x;
    now_act.ccw     = k.z;
    now_act.space   = k.space;
    now_act.restart = k.r;
    now_act.escape  = k.esc;
    res.keys.left  = lv;
    res.keys.right = rv;
    res.keys.down  = k.down | k.s;
    res.keys.pulse = kear_pkg::action_t'(now_act & ~prev_actions);
    prev_actions   = now_act;

    if (lv && !rv) want = kear_pkg::MOVE_LEFT;
    else if (rv && !lv) want = kear_pkg::MOVE_RIGHT;
    else want = kear_pkg::MOVE_NONE;

    res.move = kear_pkg::MOVE_NONE;
    if (want == kear_pkg::MOVE_NONE) begin
      held_dir   = kear_pkg::MOVE_NONE;
      delay_cnt  = '0;
      period_cnt = '0;
    end else if (held_dir != want) begin
      held_dir   = want;
      delay_cnt  = '0;
      period_cnt = '0;
      res.move   = want;
    end else if (delay_cnt < shift_delay_q) begin
      delay_cnt = delay_cnt + 8'd1;
    end else begin
      period_cnt = period_cnt + 8'd1;
      if (period_cnt >= repeat_period_q) begin
        period_cnt = '0;
        res.move   = want;
      end
    end
    return res;
  endfunction

  // Every stimulus task below starts and ends at a falling edge.
  task automatic send_tick(input kear_pkg::raw_keys_t k);
    int gap;
    gap = feed_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_up_i    <= k.up;
    key_x_i     <= k.x;
    key_z_i     <= k.z;
    key_space_i <= k.space;
    key_r_i     <= k.r;
    key_esc_i   <= k.esc;
    key_left_i  <= k.left;
    key_a_i     <= k.a;
    key_right_i <= k.right;
    key_d_i     <= k.d;
    key_down_i  <= k.down;
    key_s_i     <= k.s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_ticks.push_back(predict_tick(k));
    @(negedge clk_i);
  endtask

  // Stops sending and lets every result in flight come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx == kear_pkg::CFG_SHIFT_DELAY) shift_delay_q = value;
    else repeat_period_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_timing(input logic [7:0] sd, input logic [7:0] rp);
    wait_idle();
    set_reg(kear_pkg::CFG_SHIFT_DELAY, sd);
    set_reg(kear_pkg::CFG_REPEAT_PERIOD, rp);
  endtask

  // Random keys shaped by kind: 0-3 left held, 4-6 right held, 7 both,
  // 8 neither, 9 pure noise. Action keys and down are always random.
  function automatic kear_pkg::raw_keys_t make_keys(input int kind);
    kear_pkg::raw_keys_t k;
    k = kear_pkg::raw_keys_t'($urandom);
    if (kind <= 3) begin
      k.right = 1'b0;
      k.d     = 1'b0;
      if (!(k.left || k.a)) begin
        if ($urandom_range(0, 1)) k.left = 1'b1;
        else k.a = 1'b1;
      end
    end else if (kind <= 6) begin
      k.left = 1'b0;
      k.a    = 1'b0;
      if (!(k.right || k.d)) begin
        if ($urandom_range(0, 1)) k.right = 1'b1;
        else k.d = 1'b1;
      end
    end else if (kind == 7) begin
      if (!(k.left || k.a)) k.a = 1'b1;
      if (!(k.right || k.d)) k.right = 1'b1;
    end else if (kind == 8) begin
      k.left  = 1'b0;
      k.a     = 1'b0;
      k.right = 1'b0;
      k.d     = 1'b0;
    end
    return k;
  endfunction

  task automatic play_phase(input logic [7:0] sd, input logic [7:0] rp, input int n_items);
    int sent;
    int hold;
    int kind;
    int max_hold;
    set_timing(sd, rp);
    feed_idle = ($urandom_range(0, 3) != 0);
    sink_idle = ($urandom_range(0, 3) != 0);
    max_hold  = sd + 3 * rp + 4;
    if (max_hold > 40) max_hold = 40;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      hold = (kind >= 7) ? $urandom_range(1, 4) : $urandom_range(1, max_hold);
      repeat (hold) begin
        send_tick(make_keys(kind));
        sent++;
      end
    end
  endtask

  task automatic test_edge_pulses();
    // Columns: up x z space r esc | left a right d down s.
    logic [11:0] seq [0:10];
    seq = '{12'b000000_000000, 12'b100000_000000, 12'b010000_000000,
            12'b001000_000000, 12'b000100_000000, 12'b000010_000000,
            12'b000001_000000, 12'b111111_111111, 12'b111111_111111,
            12'b000000_000010, 12'b000000_000001};
    feed_idle = 1'b1;
    sink_idle = 1'b1;
    foreach (seq[i]) send_tick(kear_pkg::raw_keys_t'(seq[i]));
  endtask

  task automatic test_shift_timing();
    set_timing(8'd1, 8'd2);
    repeat (5) send_tick(kear_pkg::raw_keys_t'(12'b000000_100000));
    send_tick(kear_pkg::raw_keys_t'(12'b000000_100100));
    send_tick(kear_pkg::raw_keys_t'(12'b000000_000100));
    send_tick(kear_pkg::raw_keys_t'(12'b000000_010000));
    send_tick(kear_pkg::raw_keys_t'(12'b000000_000000));
    // No delay and no period: a held key moves on every tick.
    set_timing(8'd0, 8'd0);
    repeat (3) send_tick(kear_pkg::raw_keys_t'(12'b000000_001000));
    send_tick(kear_pkg::raw_keys_t'(12'b000000_000000));
  endtask

  // The sink holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    wait_idle();
    feed_idle        = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 60;
    repeat (20) send_tick(make_keys($urandom_range(0, 9)));
  endtask

  task automatic test_random_play();
    play_phase(kear_pkg::SHIFT_DELAY_RST, kear_pkg::REPEAT_PERIOD_RST, 150);
    play_phase(8'd0, 8'd0, 120);
    play_phase(8'd1, 8'd1, 120);
    play_phase(8'd3, 8'd5, 120);
    play_phase(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)), 120);
  endtask

  // Largest settings, then both shortened while the direction stays held.
  task automatic test_long_hold();
    set_timing(8'd255, 8'd255);
    feed_idle = 1'b0;
    sink_idle = 1'b1;
    repeat (262) send_tick(make_keys(0));
    set_timing(8'd5, 8'd3);
    repeat (12) send_tick(make_keys(0));
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_beat
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        note_mismatch("beat with nothing expected", 0, 1);
      end else begin
        want = expected_ticks.pop_front();
        if (left_level_o !== want.keys.left)
          note_mismatch("left_level", want.keys.left, left_level_o);
        if (right_level_o !== want.keys.right)
          note_mismatch("right_level", want.keys.right, right_level_o);
        if (down_level_o !== want.keys.down)
          note_mismatch("down_level", want.keys.down, down_level_o);
        if (rotate_cw_pulse_o !== want.keys.pulse.cw)
          note_mismatch("rotate_cw_pulse", want.keys.pulse.cw, rotate_cw_pulse_o);
        if (rotate_ccw_pulse_o !== want.keys.pulse.ccw)
          note_mismatch("rotate_ccw_pulse", want.keys.pulse.ccw, rotate_ccw_pulse_o);
        if (space_pulse_o !== want.keys.pulse.space)
          note_mismatch("space_pulse", want.keys.pulse.space, space_pulse_o);
        if (restart_pulse_o !== want.keys.pulse.restart)
          note_mismatch("restart_pulse", want.keys.pulse.restart, restart_pulse_o);
        if (escape_pulse_o !== want.keys.pulse.escape)
          note_mismatch("escape_pulse", want.keys.pulse.escape, escape_pulse_o);
        if (horizontal_move_o !== want.move)
          note_mismatch("horizontal_move", want.move, $signed(horizontal_move_o));
      end
    end
  end

  initial begin : sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_idle ? $urandom_range(0, 10) : 0;
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : main
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = kear_pkg::CFG_SHIFT_DELAY;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    {key_up_i, key_x_i, key_z_i, key_space_i, key_r_i, key_esc_i} = '0;
    {key_left_i, key_a_i, key_right_i, key_d_i, key_down_i, key_s_i} = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_pulses();
    test_shift_timing();
    test_backpressure();
    test_random_play();
    test_long_hold();

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kear_pkg.sv
rtl/kear_keymap.sv
rtl/kear_shift.sv
rtl/key_edge_and_autorepeat.sv
bench/key_edge_and_autorepeat_tb.sv
